/* sv/kmi_pkg.sv */
// Shared types and constants for the keyframe matrix interpolator.
package kmi_pkg;

	localparam int MAT_ELEMS = 16;
	localparam int ELEM_W    = 4;

	localparam logic [1:0] MODE_WR_TIME = 2'd0;
	localparam logic [1:0] MODE_WR_ELEM = 2'd1;
	localparam logic [1:0] MODE_EVAL    = 2'd2;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	typedef struct packed {
		logic [1:0]         mode;
		logic [1:0]         channel;
		logic [5:0]         key_index;
		logic [3:0]         element;
		logic signed [31:0] load_value;
		logic signed [31:0] sample_time;
	} cmd_t;

	typedef struct packed {
		logic [3:0]         element_res;
		logic signed [31:0] value;
		logic               saturated;
		logic               last;
	} result_t;

endpackage

/* sv/kmi_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module kmi_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] sh_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   r2;
	logic [DEN_W:0]   diff;
	logic             geq;

	assign r2   = {rem_q, sh_q[NUM_W-1]};
	assign geq  = r2 >= {1'b0, den_q};
	assign diff = r2 - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sh_q  <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			sh_q  <= {sh_q[NUM_W-2:0], geq};
			rem_q <= geq ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

endmodule

/* sv/keyframe_matrix_interpolator.sv */
// Top level: keyframe tables, segment search, fraction divide and element blend.
//
// Load beats (key time or matrix element writes) never raise busy. An evaluate
// beat on a valid channel raises busy through a search over the single read
// port of the key time memory, the setup states PREP and DGO, the divider with
// one quotient bit per cycle (skipped when the two segment times are equal),
// then a pass per element through RDA, RDB, DIFF, MLO, MHI, SH and OUT, set by
// the one matrix memory read port and the shared 33x32 multiplier used twice
// per element. The sixteen results come out one at a time, each held for one
// cycle under result_valid; the receiver cannot stall them. key_count is
// sampled when the evaluate beat is taken.
module keyframe_matrix_interpolator #(
	parameter int MAX_KEYS  = 64,
	parameter int CHANNELS  = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  kmi_pkg::cmd_t    cmd,
	output kmi_pkg::result_t result,
	output logic             result_valid,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [6:0]       cfg_data
);

	localparam int KEY_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int KC_W     = $clog2(MAX_KEYS + 1);
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int EL_W     = kmi_pkg::ELEM_W;
	localparam int T_DEPTH  = CHANNELS * (2 ** KEY_W);
	localparam int M_DEPTH  = T_DEPTH * (2 ** EL_W);
	localparam int NUM_W    = 33 + FRAC_BITS;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SRCH = 4'd1;
	localparam logic [3:0] ST_PREP = 4'd2;
	localparam logic [3:0] ST_DGO  = 4'd3;
	localparam logic [3:0] ST_DIV  = 4'd4;
	localparam logic [3:0] ST_RDA  = 4'd5;
	localparam logic [3:0] ST_RDB  = 4'd6;
	localparam logic [3:0] ST_DIFF = 4'd7;
	localparam logic [3:0] ST_MLO  = 4'd8;
	localparam logic [3:0] ST_MHI  = 4'd9;
	localparam logic [3:0] ST_SH   = 4'd10;
	localparam logic [3:0] ST_OUT  = 4'd11;

	localparam logic [34:0] SH_LIM = 35'h4_0000_0000;

	logic [3:0]  state_q;
	logic [6:0]  key_count_q;

	logic [31:0] time_mem [T_DEPTH];
	logic [31:0] mat_mem  [M_DEPTH];
	logic [31:0] t_rdata_q;
	logic [31:0] m_rdata_q;
	logic [CH_W+KEY_W-1:0]      t_raddr;
	logic [CH_W+KEY_W+EL_W-1:0] m_raddr;

	logic                accept;
	logic                chan_ok;
	logic                key_ok;
	logic [KC_W-1:0]     kc_now;

	logic [CH_W-1:0]     ch_q;
	logic [KC_W-1:0]     kc_q;
	logic [KC_W-1:0]     k_q;
	logic                have_q;
	logic signed [31:0]  ts_q;
	logic signed [31:0]  prev_q;
	logic signed [31:0]  t0_q;
	logic signed [31:0]  t1_q;
	logic [KEY_W-1:0]    seg_q;
	logic [32:0]         tn_q;
	logic [32:0]         dn_q;
	logic                qneg_q;
	logic [NUM_W-1:0]    q_q;
	logic [EL_W-1:0]     i_q;
	logic [31:0]         a_q;
	logic [32:0]         md_q;
	logic                neg_q;
	logic [64:0]         lo_q;
	logic [64:0]         hi_q;
	logic [34:0]         sh_q;
	kmi_pkg::result_t    result_q;
	logic                result_valid_q;

	logic signed [31:0]  cur;
	logic                hit;
	logic [32:0]         tn_abs;
	logic [32:0]         dn_abs;
	logic                div_go;
	logic                div_done;
	logic [NUM_W-1:0]    div_quo;
	logic [32:0]         d_ab;
	logic [31:0]         mul_b;
	logic [64:0]         mul_p;
	logic [65:0]         sh_sum;
	logic [34:0]         sh_next;
	logic [35:0]         s_ext;
	logic                sat_hi;
	logic                sat_lo;

	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign chan_ok   = 32'(cmd.channel) < 32'(CHANNELS);
	assign key_ok    = 32'(cmd.key_index) < 32'(MAX_KEYS);

	always_comb begin
		if (key_count_q < 7'd2) begin
			kc_now = KC_W'(2);
		end else if (32'(key_count_q) > 32'(MAX_KEYS)) begin
			kc_now = KC_W'(MAX_KEYS);
		end else begin
			kc_now = KC_W'(key_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= 7'd2;
		end else if (cfg_valid && cfg_ready) begin
			key_count_q <= cfg_data;
		end
	end

	// key time and matrix memories
	assign t_raddr = {ch_q, k_q[KEY_W-1:0]};

	always_comb begin
		case (state_q)
			ST_RDB:  m_raddr = {ch_q, seg_q + KEY_W'(1), i_q};
			default: m_raddr = {ch_q, seg_q, i_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && chan_ok && key_ok && cmd.mode == kmi_pkg::MODE_WR_TIME) begin
			time_mem[{CH_W'(cmd.channel), KEY_W'(cmd.key_index)}] <= cmd.load_value;
		end
		t_rdata_q <= time_mem[t_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && chan_ok && key_ok && cmd.mode == kmi_pkg::MODE_WR_ELEM) begin
			mat_mem[{CH_W'(cmd.channel), KEY_W'(cmd.key_index), cmd.element}] <=
				cmd.load_value;
		end
		m_rdata_q <= mat_mem[m_raddr];
	end

	// segment search compare
	assign cur = $signed(t_rdata_q);
	assign hit = (ts_q >= prev_q) && (ts_q < cur);

	// fraction divide
	assign tn_abs = tn_q[32] ? 33'(-tn_q) : tn_q;
	assign dn_abs = dn_q[32] ? 33'(-dn_q) : dn_q;
	assign div_go = (state_q == ST_DGO) && (dn_q != '0);

	kmi_div #(
		.NUM_W (NUM_W),
		.DEN_W (33)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    ({tn_abs, {FRAC_BITS{1'b0}}}),
		.den    (dn_abs),
		.done   (div_done),
		.quo    (div_quo)
	);

	// blend datapath
	assign d_ab  = {m_rdata_q[31], m_rdata_q} - {a_q[31], a_q};
	assign mul_b = (state_q == ST_MLO) ? q_q[31:0]
		: {{(64 - NUM_W){1'b0}}, q_q[NUM_W-1:32]};
	assign mul_p = 65'(md_q) * 65'(mul_b);

	assign sh_sum = (66'(hi_q[FRAC_BITS+1:0]) << (32 - FRAC_BITS))
		+ 66'(lo_q >> FRAC_BITS);

	always_comb begin
		if (|hi_q[64:FRAC_BITS+2]) begin
			sh_next = SH_LIM;
		end else if (sh_sum > 66'(SH_LIM)) begin
			sh_next = SH_LIM;
		end else begin
			sh_next = sh_sum[34:0];
		end
	end

	assign s_ext  = neg_q ? ({{4{a_q[31]}}, a_q} - {1'b0, sh_q})
		: ({{4{a_q[31]}}, a_q} + {1'b0, sh_q});
	assign sat_hi = $signed(s_ext) > 36'(kmi_pkg::Q_MAX);
	assign sat_lo = $signed(s_ext) < 36'(kmi_pkg::Q_MIN);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			k_q            <= '0;
			have_q         <= 1'b0;
			i_q            <= '0;
		end else begin
			result_valid_q <= state_q == ST_OUT;
			case (state_q)
				ST_IDLE: begin
					if (accept && chan_ok && cmd.mode == kmi_pkg::MODE_EVAL) begin
						k_q     <= '0;
						have_q  <= 1'b0;
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (!have_q) begin
						have_q <= 1'b1;
						k_q    <= k_q + KC_W'(1);
					end else if (k_q == KC_W'(1)) begin
						k_q <= k_q + KC_W'(1);
					end else if (hit || k_q == kc_q) begin
						state_q <= ST_PREP;
					end else begin
						k_q <= k_q + KC_W'(1);
					end
				end
				ST_PREP: state_q <= ST_DGO;
				ST_DGO: begin
					i_q     <= '0;
					state_q <= (dn_q == '0) ? ST_RDA : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_RDA;
					end
				end
				ST_RDA:  state_q <= ST_RDB;
				ST_RDB:  state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_MLO;
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_SH;
				ST_SH:   state_q <= ST_OUT;
				ST_OUT: begin
					i_q     <= i_q + EL_W'(1);
					state_q <= (i_q == EL_W'(kmi_pkg::MAT_ELEMS - 1)) ? ST_IDLE : ST_RDA;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ch_q <= CH_W'(cmd.channel);
				ts_q <= cmd.sample_time;
				kc_q <= kc_now;
			end
			ST_SRCH: begin
				if (have_q) begin
					prev_q <= cur;
					t0_q   <= prev_q;
					t1_q   <= cur;
					seg_q  <= KEY_W'(k_q - KC_W'(2));
				end
			end
			ST_PREP: begin
				tn_q <= {ts_q[31], ts_q} - {t0_q[31], t0_q};
				dn_q <= {t1_q[31], t1_q} - {t0_q[31], t0_q};
			end
			ST_DGO: begin
				qneg_q <= tn_q[32] ^ dn_q[32];
				q_q    <= '0;
			end
			ST_DIV: begin
				if (div_done) begin
					q_q <= div_quo;
				end
			end
			ST_RDB: a_q <= m_rdata_q;
			ST_DIFF: begin
				md_q  <= d_ab[32] ? 33'(-d_ab) : d_ab;
				neg_q <= d_ab[32] ^ qneg_q;
			end
			ST_MLO: lo_q <= mul_p;
			ST_MHI: hi_q <= mul_p;
			ST_SH:  sh_q <= sh_next;
			ST_OUT: begin
				result_q.element_res <= i_q;
				result_q.value       <= sat_hi ? kmi_pkg::Q_MAX
					: (sat_lo ? kmi_pkg::Q_MIN : $signed(s_ext[31:0]));
				result_q.saturated   <= sat_hi || sat_lo;
				result_q.last        <= i_q == EL_W'(kmi_pkg::MAT_ELEMS - 1);
			end
			default: ;
		endcase
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

/* sv/kmi_checker.sv */
// Port-level assertions for the keyframe matrix interpolator, bound to the top.
module kmi_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input kmi_pkg::cmd_t    cmd,
	input kmi_pkg::result_t result,
	input logic             result_valid
);

	// load beats never occupy the block
	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.mode != kmi_pkg::MODE_EVAL |=> !busy)
		else $error("load beat raised busy");

	// results are spaced, never in adjacent cycles
	a_result_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("results in adjacent cycles");

	// a run ends with its last element
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("busy after last element");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("idle in the middle of a run");

	// clipped values sit on a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |->
			result.value == kmi_pkg::Q_MAX || result.value == kmi_pkg::Q_MIN)
		else $error("saturated value off the rails");

endmodule

bind keyframe_matrix_interpolator kmi_checker u_kmi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.cmd          (cmd),
	.result       (result),
	.result_valid (result_valid)
);
